FILE: hdl/md5_pkg.sv
// md5 package: payload structs, round constants and helper functions
// used by the front end, the round engine and the top level; no dependencies
package md5_pkg;

    typedef struct packed {
        logic [63:0] message_data;
        logic [3:0]  byte_count;
        logic        end_of_message;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_half;
        logic        half_index;
        logic        last_half;
    } md5_out_t;

    // item passed from front end to back end: normalized bytes and flag
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        eom;
    } md5_cmd_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index for round i
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage

FILE: hdl/md5_front.sv
// md5 front end: accepts items, saturates the byte count, drops ignored bits
// and queues normalized commands for the back end; depends on md5_pkg
module md5_front import md5_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  md5_in_t  s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output md5_cmd_t q_data
);

    md5_cmd_t       mem_reg [QDEPTH];
    logic [QAW:0]   wptr_reg, rptr_reg;
    logic [3:0]     cnt;
    logic [63:0]    mask;

    assign s_ready = (wptr_reg - rptr_reg) != 3'(QDEPTH);
    assign q_valid = wptr_reg != rptr_reg;
    assign q_data  = mem_reg[rptr_reg[QAW-1:0]];

    // classify: saturate count, clear bytes above it
    always_comb begin
        cnt  = (s_data.byte_count > 4'd8) ? 4'd8 : s_data.byte_count;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < cnt) mask[8*i +: 8] = 8'hff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                mem_reg[wptr_reg[QAW-1:0]] <= '{data: s_data.message_data & mask,
                                                count: cnt, eom: s_data.end_of_message};
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (q_valid && q_ready) rptr_reg <= rptr_reg + 1'b1;
        end
    end

endmodule

FILE: hdl/md5_back.sv
// md5 back end: byte packing into a block register, padding sequencer,
// one-round-per-cycle compression and digest output; depends on md5_pkg
module md5_back import md5_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  md5_cmd_t q_data,
    output logic     m_valid,
    input  logic     m_ready,
    output md5_out_t m_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_ABSORB, S_ROUND, S_PAD, S_OUT0, S_OUT1
    } state_t;

    state_t       state_reg;
    logic [511:0] blk_reg;
    logic [31:0]  h_reg [4];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [5:0]   fill_reg, rnd_reg;
    logic [63:0]  bits_reg, len_reg;
    logic [63:0]  data_reg;
    logic [3:0]   left_reg;
    logic         eom_reg, pad_reg, padded_reg;
    logic         padding_reg, lenok_reg;

    // single round datapath
    logic [31:0] f, m, sum, rot;
    logic [4:0]  s;
    always_comb begin
        case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        m   = blk_reg[32*md5_g(rnd_reg) +: 32];
        sum = a_reg + f + md5_k(rnd_reg) + m;
        s   = md5_rot(rnd_reg);
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    assign q_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT0 || state_reg == S_OUT1;
    always_comb begin
        m_data.half_index = state_reg == S_OUT1;
        m_data.last_half  = state_reg == S_OUT1;
        m_data.digest_half = (state_reg == S_OUT1) ? {h_reg[3], h_reg[2]}
                                                   : {h_reg[1], h_reg[0]};
    end

    // sequencer, one byte per cycle while absorbing or padding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            pad_reg   <= 1'b0;
            h_reg     <= '{INIT_A, INIT_B, INIT_C, INIT_D};
        end else begin
            case (state_reg)
                S_IDLE: if (q_valid) begin
                    data_reg    <= q_data.data;
                    left_reg    <= q_data.count;
                    eom_reg     <= q_data.eom;
                    padded_reg  <= 1'b0;
                    padding_reg <= 1'b0;
                    bits_reg    <= bits_reg + {57'd0, q_data.count, 3'd0};
                    len_reg     <= bits_reg + {57'd0, q_data.count, 3'd0};
                    state_reg   <= S_ABSORB;
                end
                S_ABSORB: begin
                    if (left_reg == 4'd0) begin
                        if (eom_reg) begin
                            pad_reg     <= 1'b1;
                            padding_reg <= 1'b1;
                            state_reg   <= S_PAD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        blk_reg[8*fill_reg +: 8] <= data_reg[7:0];
                        data_reg <= data_reg >> 8;
                        left_reg <= left_reg - 1'b1;
                        fill_reg <= fill_reg + 1'b1;
                        if (fill_reg == 6'd63) begin
                            {a_reg, b_reg, c_reg, d_reg} <=
                                {h_reg[0], h_reg[1], h_reg[2], h_reg[3]};
                            rnd_reg   <= '0;
                            state_reg <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    a_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= b_reg;
                    b_reg <= b_reg + rot;
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63) begin
                        h_reg[0] <= h_reg[0] + d_reg;
                        h_reg[1] <= h_reg[1] + b_reg + rot;
                        h_reg[2] <= h_reg[2] + b_reg;
                        h_reg[3] <= h_reg[3] + c_reg;
                        if (padded_reg) state_reg <= S_OUT0;
                        else if (padding_reg) state_reg <= S_PAD;
                        else state_reg <= S_ABSORB;
                    end
                end
                S_PAD: begin
                    if (pad_reg) begin
                        blk_reg[8*fill_reg +: 8] <= PAD_BYTE;
                        pad_reg <= 1'b0;
                    end else if (lenok_reg && fill_reg >= LEN_POS) begin
                        blk_reg[8*fill_reg +: 8] <= len_reg[8*fill_reg[2:0] +: 8];
                    end else begin
                        blk_reg[8*fill_reg +: 8] <= 8'h00;
                    end
                    // length fits in this block only if the pad byte landed before it
                    if (fill_reg == 6'd63) lenok_reg <= 1'b1;
                    else if (pad_reg) lenok_reg <= fill_reg < LEN_POS;
                    fill_reg <= fill_reg + 1'b1;
                    if (fill_reg == 6'd63) begin
                        {a_reg, b_reg, c_reg, d_reg} <=
                            {h_reg[0], h_reg[1], h_reg[2], h_reg[3]};
                        rnd_reg    <= '0;
                        // length bytes only go in once the pad byte is placed
                        padded_reg <= !pad_reg && lenok_reg;
                        state_reg  <= S_ROUND;
                    end
                end
                S_OUT0: if (m_ready) state_reg <= S_OUT1;
                S_OUT1: if (m_ready) begin
                    h_reg     <= '{INIT_A, INIT_B, INIT_C, INIT_D};
                    bits_reg  <= '0;
                    fill_reg  <= '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/md5_message_digest.sv
// Streaming MD5 hasher. Items of up to eight bytes enter through s_, are
// queued, and a back end absorbs one byte per cycle, pausing while each full
// 64-byte block runs through the one-round-per-cycle compression unit. The
// back end takes one item from the queue, absorbs its bytes, and returns to
// idle before it can take the next item.
// End of message adds padding bytes and one or two
// compressions, then two digest halves on m_.
// Depends on md5_pkg, md5_front, md5_back.
module md5_message_digest import md5_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  md5_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output md5_out_t m_data
);

    logic     q_valid, q_ready;
    md5_cmd_t q_data;

    md5_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data
    );

    md5_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );

    // first half never carries the last flag, second always does
    a_half: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.half_index == m_data.last_half)) else $error("half flags");
    // a taken first half is followed by the second
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_half) |=> (m_valid && m_data.last_half))
        else $error("missing second half");
    // queue hands nothing to a busy back end
    a_q: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> !q_ready) else $error("back end took two items");

endmodule

FILE: tb/tb.sv
// testbench for md5_message_digest: random and directed message streams,
// digests predicted by an in-bench md5 model and checked by a scoreboard
// depends on md5_pkg and the md5_message_digest rtl
`timescale 1ns / 100ps

module tb;
    import md5_pkg::*;

    localparam int MAX_CYCLES = 2000000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    md5_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    md5_out_t m_data;

    int error_count = 0;
    int cycle_count = 0;

    md5_message_digest dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // digest predictor and store of pending digest halves
    class digest_scoreboard;
        logic [31:0] chain [4];
        logic [7:0]  blk [64];
        logic [63:0] bits;
        logic [5:0]  fill;
        md5_out_t    pending [$];

        function new();
            init_chain();
        endfunction

        function void init_chain();
            chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
            bits = '0;
            fill = '0;
        endfunction

        function logic [31:0] k_of(int i);
            logic [31:0] kt [64] = '{
                32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
            return kt[i];
        endfunction

        function void compress_block();
            int rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                             6, 10, 15, 21};
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, f, t, s;
            int g, ph, sh;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            for (int i = 0; i < 64; i++) begin
                ph = i / 16;
                case (ph)
                    0: begin f = (b & c) | (~b & d); g = i; end
                    1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
                    2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
                    default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
                endcase
                sh = rot[ph*4 + i%4];
                s = a + f + k_of(i) + w[g];
                t = d; d = c; c = b;
                b = b + ((s << sh) | (s >> (32 - sh)));
                a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        endfunction

        function void absorb_byte(logic [7:0] v);
            blk[fill] = v;
            fill++;
            if (fill == 0)
                compress_block();
        endfunction

        // accepted input transfer
        function void note_input(md5_in_t it);
            int n;
            logic [63:0] len;
            md5_out_t r;
            n = (it.byte_count > 8) ? 8 : it.byte_count;
            for (int i = 0; i < n; i++)
                absorb_byte(it.message_data[8*i +: 8]);
            bits += 64'(n * 8);
            if (!it.end_of_message)
                return;
            len = bits;
            absorb_byte(8'h80);
            while (fill != 6'd56)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(len[8*i +: 8]);
            r.digest_half = {chain[1], chain[0]}; r.half_index = 0; r.last_half = 0;
            pending.push_back(r);
            r.digest_half = {chain[3], chain[2]}; r.half_index = 1; r.last_half = 1;
            pending.push_back(r);
            init_chain();
        endfunction

        // accepted result transfer
        task check_result(md5_out_t got);
            md5_out_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", got.digest_half, '0);
                return;
            end
            want = pending.pop_front();
            if (got.digest_half !== want.digest_half)
                report_mismatch("digest_half", got.digest_half, want.digest_half);
            if (got.half_index !== want.half_index)
                report_mismatch("half_index", 64'(got.half_index), 64'(want.half_index));
            if (got.last_half !== want.last_half)
                report_mismatch("last_half", 64'(got.last_half), 64'(want.last_half));
        endtask
    endclass

    digest_scoreboard sb = new();

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // monitor both channels
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // result side stall pattern
    initial begin
        int w;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (w > 0) begin
                m_ready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk iff m_valid);
        end
    end

    bit quiet_phase = 0;

    task automatic send_item(input logic [63:0] d, input logic [3:0] n, input logic e);
        int w;
        w = quiet_phase ? 0 : $urandom_range(0, 16);
        if (w > 0) begin
            s_valid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= '{message_data: d, byte_count: n, end_of_message: e};
        @(posedge aclk iff s_ready);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // stimulus
    initial begin
        int len, sent, wait_cnt;
        s_valid = 0;
        s_data  = '0;
        aresetn = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty message, extremes, over-count, block boundaries
        send_item('0, 4'd0, 1);
        send_item('1, 4'd8, 1);
        send_item('0, 4'd8, 1);
        send_item(rand64(), 4'd15, 1);
        send_item(rand64(), 4'd9, 0);
        send_item(rand64(), 4'd3, 1);
        for (int i = 0; i < 7; i++) send_item(rand64(), 4'd8, 0);
        send_item(rand64(), 4'd8, 1);
        for (int i = 0; i < 7; i++) send_item('1, 4'd8, 0);
        send_item('1, 4'd0, 1);

        // random messages with random lengths and random byte counts, over-counts included
        sent = 0;
        while (sent < 520) begin
            quiet_phase = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                              : $urandom_range(0, 9);
            for (int i = 0; i < len; i++) begin
                send_item(rand64(), 4'($urandom_range(0, 15)), 0);
                sent++;
            end
            send_item(rand64(), 4'($urandom_range(0, 15)), 1);
            sent++;
        end
        s_valid <= 0;
        quiet_phase = 0;

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (300) @(posedge aclk);
        if (error_count == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
